[src/slgc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slgc_pkg: shared constants for the sorted LRU glyph cache tag table
// Fixed field widths for codes, slots and the size limit.
// ----------------------------------------------------------------------------
package slgc_pkg;
	localparam int CodeBits  = 16;
	localparam int SlotBits  = 8;
	localparam int LimitBits = 9;
endpackage
`default_nettype wire

[src/slgc_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slgc_mem: tag entry memory
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module slgc_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 56
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[src/sorted_lru_glyph_cache_tags.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_lru_glyph_cache_tags: sorted tag table of an LRU glyph cache
// A hit needs only the binary search over the sorted codes. A miss adds one
// pass over the table to find the oldest stamp (misses at the configured
// limit only), one pass to shift entries, and one pass to rebase stamps
// after an eviction, one entry at a time on the single memory port.
// One lookup is in flight at a time; a result waits in an output register.
// ----------------------------------------------------------------------------
module sorted_lru_glyph_cache_tags #(
	parameter int CAPACITY   = 256,
	parameter int STAMP_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [slgc_pkg::LimitBits-1:0] cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [slgc_pkg::CodeBits-1:0] char_code,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               hit,
	output logic [slgc_pkg::SlotBits-1:0]      slot,
	output logic                               evicted,
	output logic [slgc_pkg::CodeBits-1:0]      evicted_code
);
	import slgc_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(CAPACITY);
	localparam int EW = CodeBits + SW + STAMP_BITS;
	localparam logic [STAMP_BITS-1:0] SMAX = '1;

	typedef enum logic [3:0] {
		IDLE, S_RD, S_CMP, M_RD, M_CMP, SH_RD, SH_WR, PUT, RB_RD, RB_WR, DONE
	} state_t;

	state_t state_q;
	logic [LimitBits-1:0]  limit_q;
	logic [CW-1:0]         count_q, lo_q, hi_q, mid_q, at_q, i_q, vic_q;
	logic [STAMP_BITS-1:0] ctr_q, low_q;
	logic [CodeBits-1:0]   code_q, gone_q;
	logic [SW-1:0]         vslot_q;
	logic                  evict_q, up_q;
	logic [EW-1:0]         hold_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [CodeBits-1:0]   r_code;
	logic [SW-1:0]         r_slot;
	logic [STAMP_BITS-1:0] r_stamp;
	logic [CW-1:0]         limit;
	logic [CW:0]           sum;

	assign {r_code, r_slot, r_stamp} = rdata;
	assign limit = (32'(limit_q) > CAPACITY) ? CW'(CAPACITY) : CW'(limit_q);
	assign sum   = {1'b0, lo_q} + {1'b0, hi_q};

	slgc_mem #(.DEPTH(CAPACITY), .WIDTH(EW)) u_mem (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign in_stall = (state_q != IDLE) || out_valid;

	always_comb begin
		we = 1'b0; waddr = '0; wdata = '0; raddr = AW'(mid_q);
		case (state_q)
			S_RD:  raddr = AW'(sum[CW:1]);
			M_RD:  raddr = AW'(i_q);
			SH_RD: raddr = up_q ? AW'(i_q + 1'b1) : AW'(i_q - 1'b1);
			SH_WR: begin we = 1'b1; waddr = AW'(i_q); wdata = rdata; end
			PUT: begin
				we = 1'b1; waddr = AW'(at_q);
				wdata = {code_q, evict_q ? vslot_q : SW'(count_q), ctr_q};
			end
			RB_RD: raddr = AW'(i_q);
			RB_WR: begin
				we = 1'b1; waddr = AW'(i_q);
				wdata = {r_code, r_slot, r_stamp - low_q};
			end
			DONE: if (hit) begin
				we = 1'b1; waddr = AW'(at_q); wdata = {hold_q[EW-1:STAMP_BITS], ctr_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE; limit_q <= 9'd256; count_q <= '0; ctr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				IDLE: if (in_valid && !in_stall) begin
					code_q <= char_code;
					hit <= 1'b0; slot <= '0; evicted <= 1'b0; evicted_code <= '0;
					if (limit == '0) begin
						out_valid <= 1'b1;
					end else begin
						if (ctr_q != SMAX) ctr_q <= ctr_q + 1'b1;
						lo_q <= '0; hi_q <= count_q; at_q <= '0;
						state_q <= (count_q == '0) ? M_RD : S_RD;
						if (count_q == '0) i_q <= '0;
					end
				end
				S_RD: begin
					mid_q <= sum[CW:1];
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (r_code == code_q) begin
						hit <= 1'b1; slot <= SlotBits'(r_slot);
						at_q <= mid_q; hold_q <= rdata;
						state_q <= DONE;
					end else begin
						if (code_q < r_code) hi_q <= mid_q;
						else lo_q <= mid_q + 1'b1;
						if ((code_q < r_code) ? (lo_q < mid_q) : (mid_q + 1'b1 < hi_q))
							state_q <= S_RD;
						else begin
							at_q <= (code_q < r_code) ? lo_q : mid_q + 1'b1;
							i_q <= '0; state_q <= M_RD;
						end
					end
				end
				M_RD: begin
					evict_q <= (count_q >= limit);
					if (count_q < limit) begin
						up_q <= 1'b0; i_q <= count_q;
						state_q <= (count_q == at_q) ? PUT : SH_RD;
					end else state_q <= M_CMP;
				end
				M_CMP: begin
					// min scan, strict less keeps the lowest index on ties
					if (i_q == '0 || r_stamp < low_q) begin
						low_q <= r_stamp; vic_q <= i_q;
						vslot_q <= r_slot; gone_q <= r_code;
					end
					if (i_q + 1'b1 < count_q) begin
						i_q <= i_q + 1'b1; state_q <= M_RD;
					end else begin
						logic [CW-1:0] v, a;
						v = (i_q == '0 || r_stamp < low_q) ? i_q : vic_q;
						a = (at_q > v) ? at_q - 1'b1 : at_q;
						at_q <= a; up_q <= (at_q > v); i_q <= v;
						state_q <= (a == v) ? PUT : SH_RD;
					end
				end
				SH_RD: state_q <= SH_WR;
				SH_WR: begin
					i_q <= up_q ? i_q + 1'b1 : i_q - 1'b1;
					state_q <= ((up_q ? i_q + 1'b1 : i_q - 1'b1) == at_q) ? PUT : SH_RD;
				end
				PUT: begin
					slot <= SlotBits'(evict_q ? vslot_q : SW'(count_q));
					if (evict_q) begin
						evicted <= 1'b1; evicted_code <= gone_q;
						ctr_q <= ctr_q - low_q; i_q <= '0;
						state_q <= RB_RD;
					end else begin
						count_q <= count_q + 1'b1;
						out_valid <= 1'b1; state_q <= IDLE;
					end
				end
				RB_RD: state_q <= RB_WR;
				RB_WR: begin
					if (i_q + 1'b1 < count_q) begin
						i_q <= i_q + 1'b1; state_q <= RB_RD;
					end else begin
						out_valid <= 1'b1; state_q <= IDLE;
					end
				end
				DONE: begin
					out_valid <= 1'b1; state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("entry count above capacity");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + 1'b1)
		else $error("count jumped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != IDLE |-> in_stall) else $error("accepted while busy");
endmodule
`default_nettype wire
